@@ hw/rtl/tlbr_pkg.sv @@
// Shared codes, field widths and types for the translation table refill block.
package tlbr_pkg;

  localparam int OPCODE_W   = 2;
  localparam int PAGE_IN_W  = 20;
  localparam int FLOOR_W    = 6;
  localparam int INDEX_W    = 6;
  localparam int OUTCOME_W  = 3;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  localparam int VPN_LSB = OPCODE_W;
  localparam int PPN_LSB = VPN_LSB + PAGE_IN_W;
  localparam int WR_BIT  = PPN_LSB + PAGE_IN_W;

  localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(8);

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSTALL  = 2'd0,
    OP_READONLY = 2'd1,
    OP_FLUSH    = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_MATCHED  = 3'd0,
    OUT_FREE     = 3'd1,
    OUT_RANDOM   = 3'd2,
    OUT_READONLY = 3'd3,
    OUT_FLUSHED  = 3'd4,
    OUT_IGNORED  = 3'd5
  } outcome_t;

  typedef struct packed {
    logic valid;
    logic match;
  } cmp_t;

endpackage

@@ hw/rtl/tlb_refill_random_replace_top.sv @@
// Top level of the fully associative translation table refill block.
//
// Usage: commands arrive as words on the s_axis channel (install, make all
// valid entries readonly, flush). Each command yields exactly one result word
// on m_axis carrying the entry index written and an outcome code.
// The user must write the replacement floor through random_floor_we/random_floor_data
// only while the block is idle; the block itself does not enforce this. It bounds the wrapping replacement counter.
// Sequencing: an install sweeps every entry through one page comparator, one
// entry per cycle from the page store read port, then passes the drain,
// decide and done states before the result word. Readonly, flush and unused
// opcodes skip the sweep and go from idle to decide. One command is in flight
// at a time; s_axis_tready is high only while the sequencer is idle.
// Reset clears all valid and dirty bits, sets the replacement counter to the
// top entry and the floor to 8; page numbers are undefined until written.
// When the receiver stalls, the result word holds on m_axis and the sequencer
// waits before finishing the next command until that word is taken.
module tlb_refill_random_replace_top #(
  parameter int ENTRIES   = 64,
  parameter int PAGE_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              random_floor_we,
  input  logic [tlbr_pkg::FLOOR_W-1:0]      random_floor_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // opcode[1:0], virtual_page[21:2], physical_page[41:22], writable[42]
  input  logic [tlbr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // entry_index[5:0], outcome[8:6]
  output logic [tlbr_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import tlbr_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CW    = (IDX_W > FLOOR_W) ? IDX_W : FLOOR_W;
  localparam int KW    = (PAGE_BITS < PAGE_IN_W) ? PAGE_BITS : PAGE_IN_W;
  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_DONE
  } state_t;

  state_t               state;
  logic [FLOOR_W-1:0]   random_floor;
  logic [ENTRIES-1:0]   entry_valid;
  logic [ENTRIES-1:0]   entry_dirty;
  logic [IDX_W-1:0]     replace_counter;
  opcode_t              op;
  logic [KW-1:0]        vpn;
  logic [KW-1:0]        ppn;
  logic                 writable;
  logic [IDX_W-1:0]     scan_idx;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic                 free;
  logic [IDX_W-1:0]     free_idx;
  logic [INDEX_W-1:0]   res_index;
  outcome_t             res_outcome;
  logic [INDEX_W-1:0]   out_index;
  outcome_t             out_outcome;
  logic                 out_valid;

  logic                 store_we;
  logic [IDX_W-1:0]     slot;
  outcome_t             install_outcome;
  logic [IDX_W-1:0]     counter_next;
  logic [IDX_W-1:0]     random_slot;
  logic [CW-1:0]        cnt_ext;
  logic [CW-1:0]        floor_ext;
  logic [CW-1:0]        slot_ext;
  cmp_t                 cmp;
  logic [IDX_W-1:0]     cmp_idx;

  tlbr_page_store #(
    .ENTRIES (ENTRIES),
    .PAGE_W  (KW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .we      (store_we),
    .waddr   (slot),
    .wvpn    (vpn),
    .wppn    (ppn),
    .re      (state == S_SCAN),
    .raddr   (scan_idx),
    .key     (vpn),
    .cmp     (cmp),
    .cmp_idx (cmp_idx)
  );

  assign cnt_ext     = CW'(replace_counter);
  assign floor_ext   = CW'(random_floor);
  assign random_slot = (cnt_ext < floor_ext) ? TOP_IDX : replace_counter;
  assign counter_next = (cnt_ext <= floor_ext) ? TOP_IDX : replace_counter - 1'b1;

  always_comb begin
    if (hit) begin
      slot            = hit_idx;
      install_outcome = OUT_MATCHED;
    end else if (free) begin
      slot            = free_idx;
      install_outcome = OUT_FREE;
    end else begin
      slot            = random_slot;
      install_outcome = OUT_RANDOM;
    end
  end

  assign slot_ext = CW'(slot);
  assign store_we = (state == S_DECIDE) && (op == OP_INSTALL);

  always_ff @(posedge clk) begin
    if (rst) begin
      random_floor <= FLOOR_RESET;
    end else if (random_floor_we) begin
      random_floor <= random_floor_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      entry_valid     <= '0;
      entry_dirty     <= '0;
      replace_counter <= TOP_IDX;
      out_valid       <= 1'b0;
      scan_idx        <= '0;
      hit             <= 1'b0;
      free            <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      if (cmp.valid) begin
        if (entry_valid[cmp_idx] && cmp.match && !hit) begin
          hit     <= 1'b1;
          hit_idx <= cmp_idx;
        end
        if (!entry_valid[cmp_idx] && !free) begin
          free     <= 1'b1;
          free_idx <= cmp_idx;
        end
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op       <= opcode_t'(s_axis_tdata[OPCODE_W-1:0]);
            vpn      <= s_axis_tdata[VPN_LSB +: KW];
            ppn      <= s_axis_tdata[PPN_LSB +: KW];
            writable <= s_axis_tdata[WR_BIT];
            scan_idx <= '0;
            hit      <= 1'b0;
            free     <= 1'b0;
            if (opcode_t'(s_axis_tdata[OPCODE_W-1:0]) == OP_INSTALL) begin
              state <= S_SCAN;
            end else begin
              state <= S_DECIDE;
            end
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == TOP_IDX) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          replace_counter <= counter_next;
          case (op)
            OP_INSTALL: begin
              entry_valid[slot] <= 1'b1;
              entry_dirty[slot] <= writable;
              res_index         <= slot_ext[INDEX_W-1:0];
              res_outcome       <= install_outcome;
            end
            OP_READONLY: begin
              entry_dirty <= entry_dirty & ~entry_valid;
              res_index   <= '0;
              res_outcome <= OUT_READONLY;
            end
            OP_FLUSH: begin
              entry_valid <= '0;
              res_index   <= '0;
              res_outcome <= OUT_FLUSHED;
            end
            default: begin
              res_index   <= '0;
              res_outcome <= OUT_IGNORED;
            end
          endcase
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_valid   <= 1'b1;
            out_index   <= res_index;
            out_outcome <= res_outcome;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - INDEX_W - OUTCOME_W){1'b0}}, out_outcome, out_index};

endmodule

@@ hw/rtl/tlbr_page_store.sv @@
// Page number store with one write port and a registered compare read port.
module tlbr_page_store #(
  parameter int ENTRIES = 64,
  parameter int PAGE_W  = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       we,
  input  logic [$clog2(ENTRIES)-1:0] waddr,
  input  logic [PAGE_W-1:0]          wvpn,
  input  logic [PAGE_W-1:0]          wppn,
  input  logic                       re,
  input  logic [$clog2(ENTRIES)-1:0] raddr,
  input  logic [PAGE_W-1:0]          key,
  output tlbr_pkg::cmp_t             cmp,
  output logic [$clog2(ENTRIES)-1:0] cmp_idx
);
  import tlbr_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  logic [PAGE_W-1:0] vpn_mem [ENTRIES];
  logic [PAGE_W-1:0] ppn_mem [ENTRIES];
  logic [PAGE_W-1:0] rd_vpn;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_idx;

  always_ff @(posedge clk) begin
    if (we) begin
      vpn_mem[waddr] <= wvpn;
      ppn_mem[waddr] <= wppn;
    end
    rd_vpn <= vpn_mem[raddr];
    rd_idx <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= re;
    end
  end

  assign cmp.valid = rd_valid;
  assign cmp.match = (rd_vpn == key);
  assign cmp_idx   = rd_idx;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the translation table refill block with random replacement.
module testbench;
  import tlbr_pkg::*;

  localparam int ENTRIES = 64;
  localparam logic [INDEX_W-1:0] TOP_ENTRY = INDEX_W'(ENTRIES - 1);
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    outcome_t           outcome;
  } refill_result_t;

  class refill_scoreboard;
    logic                 entry_valid [ENTRIES];
    logic [PAGE_IN_W-1:0] entry_vpage [ENTRIES];
    logic [PAGE_IN_W-1:0] entry_ppage [ENTRIES];
    logic                 entry_dirty [ENTRIES];
    logic [INDEX_W-1:0]   replace_count;
    logic [FLOOR_W-1:0]   floor_index;
    refill_result_t       expected_results [$];
    int                   mismatches;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        entry_valid[i] = 1'b0;
        entry_vpage[i] = '0;
        entry_ppage[i] = '0;
        entry_dirty[i] = 1'b0;
      end
      replace_count = TOP_ENTRY;
      floor_index = FLOOR_RESET;
      mismatches = 0;
    endfunction

    function void set_floor(logic [FLOOR_W-1:0] value);
      floor_index = value;
    endfunction

    function void note_command(opcode_t op, logic [PAGE_IN_W-1:0] vpn,
                               logic [PAGE_IN_W-1:0] ppn, logic wr);
      refill_result_t r;
      int slot;
      bit found;
      r.index = '0;
      r.outcome = OUT_IGNORED;
      slot = 0;
      found = 1'b0;
      case (op)
        OP_INSTALL: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (!found && entry_valid[i] && entry_vpage[i] == vpn) begin
              slot = i;
              found = 1'b1;
              r.outcome = OUT_MATCHED;
            end
          end
          for (int i = 0; i < ENTRIES; i++) begin
            if (!found && !entry_valid[i]) begin
              slot = i;
              found = 1'b1;
              r.outcome = OUT_FREE;
            end
          end
          if (!found) begin
            slot = (replace_count < floor_index) ? int'(TOP_ENTRY) : int'(replace_count);
            r.outcome = OUT_RANDOM;
          end
          entry_vpage[slot] = vpn;
          entry_ppage[slot] = ppn;
          entry_dirty[slot] = wr;
          entry_valid[slot] = 1'b1;
          r.index = INDEX_W'(slot);
        end
        OP_READONLY: begin
          for (int i = 0; i < ENTRIES; i++)
            if (entry_valid[i]) entry_dirty[i] = 1'b0;
          r.outcome = OUT_READONLY;
        end
        OP_FLUSH: begin
          for (int i = 0; i < ENTRIES; i++) entry_valid[i] = 1'b0;
          r.outcome = OUT_FLUSHED;
        end
        default: ;
      endcase
      // advance the replacement counter once per command
      if (replace_count <= floor_index) replace_count = TOP_ENTRY;
      else replace_count = replace_count - 1'b1;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] word);
      refill_result_t exp_r;
      logic [INDEX_W-1:0] got_index;
      logic [OUTCOME_W-1:0] got_outcome;
      got_index = word[INDEX_W-1:0];
      got_outcome = word[INDEX_W +: OUTCOME_W];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: index %0d outcome %0d", got_index, got_outcome);
        return;
      end
      exp_r = expected_results.pop_front();
      if (got_index !== exp_r.index || got_outcome !== exp_r.outcome) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result mismatch: expected index %0d outcome %0d, got index %0d outcome %0d",
                   exp_r.index, exp_r.outcome, got_index, got_outcome);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function bit failed();
      return mismatches != 0 || expected_results.size() != 0;
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  random_floor_we;
  logic [FLOOR_W-1:0]    random_floor_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // opcode[1:0], virtual_page[21:2], physical_page[41:22], writable[42]
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // entry_index[5:0], outcome[8:6]
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  refill_scoreboard     table_sb;
  int                   send_idle_pct;
  int                   recv_idle_pct;
  int                   accepted_words;
  logic                 hold_results;
  logic [PAGE_IN_W-1:0] page_pool [96];

  tlb_refill_random_replace_top dut (
    .clk               (clk),
    .rst               (rst),
    .random_floor_we   (random_floor_we),
    .random_floor_data (random_floor_data),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) table_sb.check_result(m_axis_tdata);
    end
  end

  // hold off the receiver while the sender keeps offering words
  initial begin
    hold_results <= 1'b0;
    wait (accepted_words >= 700);
    @(posedge clk);
    hold_results <= 1'b1;
    repeat (500) @(posedge clk);
    hold_results <= 1'b0;
  end

  initial begin
    #40000000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_cmd(opcode_t op, logic [PAGE_IN_W-1:0] vpn,
                          logic [PAGE_IN_W-1:0] ppn, logic wr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_DATA_W'({wr, ppn, vpn, op});
    do @(posedge clk); while (!s_axis_tready);
    table_sb.note_command(op, vpn, ppn, wr);
    accepted_words++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (table_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_floor(logic [FLOOR_W-1:0] value);
    random_floor_we <= 1'b1;
    random_floor_data <= value;
    @(posedge clk);
    random_floor_we <= 1'b0;
    table_sb.set_floor(value);
  endtask

  task automatic send_random(int count);
    int pick;
    opcode_t op;
    logic [PAGE_IN_W-1:0] vpn;
    // open with an install of a random page so each new floor is first met by an install
    send_cmd(OP_INSTALL, PAGE_IN_W'($urandom), PAGE_IN_W'($urandom), 1'($urandom));
    for (int n = 1; n < count; n++) begin
      pick = $urandom_range(199);
      if (pick == 0) op = OP_FLUSH;
      else if (pick < 13) op = OP_READONLY;
      else if (pick < 21) op = OP_UNUSED;
      else op = OP_INSTALL;
      if ($urandom_range(99) < 60) vpn = page_pool[$urandom_range(95)];
      else vpn = PAGE_IN_W'($urandom);
      send_cmd(op, vpn, PAGE_IN_W'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    logic [FLOOR_W-1:0] floors [6];
    table_sb = new();
    accepted_words = 0;
    send_idle_pct = 20;
    recv_idle_pct = 77;
    rst <= 1'b1;
    random_floor_we <= 1'b0;
    random_floor_data <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < 96; i++) page_pool[i] = PAGE_IN_W'($urandom);
    floors[0] = FLOOR_RESET;
    floors[1] = '0;
    floors[2] = '1;
    floors[3] = FLOOR_W'(20);
    floors[4] = FLOOR_W'($urandom_range(63));
    floors[5] = FLOOR_W'(1);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cmd(OP_UNUSED, '1, '1, 1'b1);
    send_cmd(OP_READONLY, '0, '0, 1'b0);
    send_cmd(OP_FLUSH, '0, '0, 1'b0);
    send_cmd(OP_INSTALL, '0, '0, 1'b0);
    send_cmd(OP_INSTALL, '1, '1, 1'b1);
    send_cmd(OP_INSTALL, '1, 20'h12345, 1'b0);
    send_cmd(OP_INSTALL, '0, '1, 1'b1);
    send_cmd(OP_INSTALL, 20'hAAAAA, 20'h55555, 1'b1);
    send_cmd(OP_INSTALL, 20'h55555, 20'hAAAAA, 1'b0);
    send_cmd(OP_READONLY, '1, '1, 1'b1);
    send_cmd(OP_INSTALL, 20'h55555, 20'h0F0F0, 1'b1);
    send_cmd(OP_FLUSH, '1, '1, 1'b1);
    send_cmd(OP_INSTALL, 20'h55555, 20'h0F0F0, 1'b1);
    send_cmd(OP_UNUSED, '0, '0, 1'b0);
    send_cmd(OP_INSTALL, '0, 20'h80001, 1'b0);
    send_random(150);
    drain();

    for (int p = 1; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 20 : (p < 4) ? 77 : 0;
      recv_idle_pct = (p < 2) ? 77 : (p < 4) ? 20 : 0;
      write_floor(floors[p]);
      send_random(150);
      drain();
    end

    repeat (70) @(posedge clk);
    if (table_sb.failed()) $display("FAILURE");
    else $display("SUCCESS");
    $finish;
  end
endmodule
